// ----- hdl/uihb_pkg.sv -----
// Shared types and constants of the UDP/IPv4/Ethernet header builder.
// No dependencies; every other file in hdl refers to this package by scoped names.
package uihb_pkg;

    // Header length in 16-bit words and the index of the final word.
    localparam int unsigned HDR_WORDS = 21;
    localparam int unsigned IDX_W     = 5;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HDR_WORDS - 1);

    // Fixed header constants.
    localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
    localparam logic [15:0] IP_VER_IHL    = 16'h4500;
    localparam logic [15:0] MAX_PAYLOAD   = 16'd65507;
    localparam logic [15:0] IP_UDP_HLEN   = 16'd28;
    localparam logic [15:0] UDP_HLEN      = 16'd8;

    // Result status codes.
    localparam logic [1:0] ST_SENT    = 2'd0;
    localparam logic [1:0] ST_NO_SMAC = 2'd1;
    localparam logic [1:0] ST_ARP     = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_CORE = 1'b0;
    localparam logic CFG_TAG  = 1'b1;

    // One header request as it moves down the pipeline.
    typedef struct packed {
        logic [47:0] dmac;
        logic [47:0] smac;
        logic [15:0] plen;
        logic [15:0] ident;
        logic [7:0]  proto;
        logic [31:0] sip;
        logic [31:0] dip;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [7:0]  link;
        logic [1:0]  status;
        logic [15:0] csum;
    } t_hdr;

endpackage

// ----- hdl/uihb_cksum.sv -----
// Three-stage pipeline that saturates the payload length and computes the IPv4 checksum.
// Depends on uihb_pkg for the request struct and header constants.
module uihb_cksum (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  uihb_pkg::t_hdr i_req,
    output logic           o_ready,
    output logic           o_valid,
    output uihb_pkg::t_hdr o_hdr,
    input  logic           i_take
);

    logic           r_v1, r_v2, r_v3;
    uihb_pkg::t_hdr r_s1, r_s2, r_s3;
    logic [17:0]    r_sum_a, r_sum_b;
    logic [16:0]    r_fold;

    logic           w_rdy1, w_rdy2, w_rdy3;
    logic [15:0]    w_plen;
    logic [15:0]    w_tot_len;
    logic [18:0]    w_sum;
    logic [15:0]    w_fold2;
    uihb_pkg::t_hdr n_s1;
    uihb_pkg::t_hdr n_s3;

    assign w_rdy3  = !r_v3 || i_take;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;
    assign o_valid = r_v3;
    assign o_hdr   = r_s3;

    always_comb begin
        w_plen = (i_req.plen > uihb_pkg::MAX_PAYLOAD) ? uihb_pkg::MAX_PAYLOAD : i_req.plen;
        w_tot_len = w_plen + uihb_pkg::IP_UDP_HLEN;
        n_s1 = i_req;
        n_s1.plen = w_plen;
    end

    // Stage two adds the partial sums and folds the carries once; stage three folds again.
    // After the first fold a carry leaves at most six in the low half, so the second fold
    // cannot carry out.
    assign w_sum   = {1'b0, r_sum_a} + {1'b0, r_sum_b};
    assign w_fold2 = r_fold[15:0] + {15'd0, r_fold[16]};

    always_comb begin
        n_s3      = r_s2;
        n_s3.csum = ~w_fold2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_s1    <= n_s1;
            r_sum_a <= {2'b00, uihb_pkg::IP_VER_IHL} + {2'b00, w_tot_len}
                     + {2'b00, i_req.ident} + {10'd0, i_req.proto};
            r_sum_b <= {2'b00, i_req.sip[31:16]} + {2'b00, i_req.sip[15:0]}
                     + {2'b00, i_req.dip[31:16]} + {2'b00, i_req.dip[15:0]};
        end
        if (w_rdy2) begin
            r_s2   <= r_s1;
            r_fold <= {1'b0, w_sum[15:0]} + {14'd0, w_sum[18:16]};
        end
        if (w_rdy3) begin
            r_s3 <= n_s3;
        end
    end

    a_hold3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && !i_take |=> r_v3 && $stable(r_s3))
        else $error("stage three lost or changed a held request");

    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && !w_rdy2 |=> r_v2)
        else $error("stalled stage two request dropped");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> r_v1 && r_v2 && r_v3 && !i_take)
        else $error("pipeline refused a request while not full");

endmodule

// ----- hdl/uihb_ser.sv -----
// Serializer that sends a finished header as 21 words, or one drop result, one per cycle.
// Depends on uihb_pkg for the request struct, status codes and word count.
module uihb_ser (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  uihb_pkg::t_hdr               i_hdr,
    output logic                         o_take,
    output logic                         o_strobe,
    output logic [15:0]                  o_header_word,
    output logic [uihb_pkg::IDX_W-1:0]   o_word_index,
    output logic                         o_last_word,
    output logic [7:0]                   o_out_link,
    output logic [1:0]                   o_status
);

    logic                        r_act;
    logic [uihb_pkg::IDX_W-1:0]  r_idx;
    uihb_pkg::t_hdr              r_hdr;
    logic                        r_strobe;
    logic [15:0]                 r_word;
    logic [uihb_pkg::IDX_W-1:0]  r_oidx;
    logic                        r_last;
    logic [7:0]                  r_link;
    logic [1:0]                  r_status;

    logic                        w_drop;
    logic                        w_fin;
    logic [15:0]                 w_word;

    assign w_drop = (r_hdr.status != uihb_pkg::ST_SENT);
    assign w_fin  = r_act && (w_drop || (r_idx == uihb_pkg::LAST_IDX));
    assign o_take = i_valid && (!r_act || w_fin);

    always_comb begin
        case (r_idx)
            5'd0:    w_word = r_hdr.dmac[47:32];
            5'd1:    w_word = r_hdr.dmac[31:16];
            5'd2:    w_word = r_hdr.dmac[15:0];
            5'd3:    w_word = r_hdr.smac[47:32];
            5'd4:    w_word = r_hdr.smac[31:16];
            5'd5:    w_word = r_hdr.smac[15:0];
            5'd6:    w_word = uihb_pkg::ETH_TYPE_IPV4;
            5'd7:    w_word = uihb_pkg::IP_VER_IHL;
            5'd8:    w_word = r_hdr.plen + uihb_pkg::IP_UDP_HLEN;
            5'd9:    w_word = r_hdr.ident;
            5'd11:   w_word = {8'd0, r_hdr.proto};
            5'd12:   w_word = r_hdr.csum;
            5'd13:   w_word = r_hdr.sip[31:16];
            5'd14:   w_word = r_hdr.sip[15:0];
            5'd15:   w_word = r_hdr.dip[31:16];
            5'd16:   w_word = r_hdr.dip[15:0];
            5'd17:   w_word = r_hdr.sport;
            5'd18:   w_word = r_hdr.dport;
            5'd19:   w_word = r_hdr.plen + uihb_pkg::UDP_HLEN;
            default: w_word = 16'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act    <= 1'b0;
            r_strobe <= 1'b0;
            r_idx    <= '0;
        end else begin
            r_strobe <= r_act;
            if (o_take) begin
                r_act <= 1'b1;
                r_idx <= '0;
            end else if (w_fin) begin
                r_act <= 1'b0;
            end else if (r_act) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_hdr <= i_hdr;
        end
        r_word   <= w_drop ? 16'd0 : w_word;
        r_oidx   <= r_idx;
        r_last   <= w_fin;
        r_link   <= w_drop ? 8'd0 : r_hdr.link;
        r_status <= r_hdr.status;
    end

    assign o_strobe      = r_strobe;
    assign o_header_word = r_word;
    assign o_word_index  = r_oidx;
    assign o_last_word   = r_last;
    assign o_out_link    = r_link;
    assign o_status      = r_status;

    a_next_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last_word |=> o_strobe && (o_word_index == $past(o_word_index) + 1'b1))
        else $error("header words not sent back to back");

    a_drop_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_status != uihb_pkg::ST_SENT) |-> o_last_word && (o_word_index == '0))
        else $error("drop result is not a single word");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_act |-> r_idx <= uihb_pkg::LAST_IDX)
        else $error("word index ran past the header");

endmodule

// ----- hdl/udp_ipv4_ethernet_header_builder_unit.sv -----
// Top level of the UDP/IPv4/Ethernet header builder: configuration registers and glue.
// Depends on uihb_pkg, uihb_cksum and uihb_ser.
//
//   channel    ports                                  handshake
//   ---------  -------------------------------------  ----------------------------------
//   request    i_local_address .. i_egress_link        taken when start is high, busy low
//   result     o_header_word .. o_status               words back to back, o_strobe marks each
//   config     i_cfg_we, i_cfg_index, i_cfg_data       written on any edge with i_cfg_we
//
// With an idle serializer, a request passes the three checksum stages, then the serializer's
// header register and its output registers, before its first word is on the result ports.
// A sent header occupies the result port for all 21 of its words and a dropped request for
// one word, so the single-word result port sets the sustained request rate.
// Up to three further requests queue in the pipeline while a header is being sent; busy
// rises only when all three stages are full and the serializer cannot take the oldest.
// Reset is synchronous and active low; it clears the valid bits and sets both
// configuration registers to zero. The receiver cannot stall the result port.
module udp_ipv4_ethernet_header_builder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_local_address,
    input  logic [31:0] i_remote_address,
    input  logic [7:0]  i_proto_number,
    input  logic [15:0] i_local_port,
    input  logic [15:0] i_remote_port,
    input  logic [15:0] i_payload_length,
    input  logic [47:0] i_source_mac,
    input  logic        i_source_mac_found,
    input  logic [47:0] i_dest_mac,
    input  logic        i_dest_mac_found,
    input  logic [7:0]  i_egress_link,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [11:0] i_cfg_data,
    output logic        o_strobe,
    output logic [15:0] o_header_word,
    output logic [4:0]  o_word_index,
    output logic        o_last_word,
    output logic [7:0]  o_out_link,
    output logic [1:0]  o_status
);

    // Configuration registers; the identification field is formed from them at acceptance.
    logic [3:0]  r_core;
    logic [11:0] r_tag;

    logic           w_ready;
    logic           w_valid3;
    logic           w_take;
    uihb_pkg::t_hdr w_req;
    uihb_pkg::t_hdr w_hdr3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_core <= 4'd0;
            r_tag  <= 12'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                uihb_pkg::CFG_CORE: r_core <= i_cfg_data[3:0];
                uihb_pkg::CFG_TAG:  r_tag  <= i_cfg_data;
                default:            r_tag  <= r_tag;
            endcase
        end
    end

    // The missing source MAC is checked first, so it wins when both lookups failed.
    always_comb begin
        w_req.dmac  = i_dest_mac;
        w_req.smac  = i_source_mac;
        w_req.plen  = i_payload_length;
        w_req.ident = {r_core, r_tag};
        w_req.proto = i_proto_number;
        w_req.sip   = i_local_address;
        w_req.dip   = i_remote_address;
        w_req.sport = i_local_port;
        w_req.dport = i_remote_port;
        w_req.link  = i_egress_link;
        w_req.csum  = 16'd0;
        if (!i_source_mac_found) begin
            w_req.status = uihb_pkg::ST_NO_SMAC;
        end else if (!i_dest_mac_found) begin
            w_req.status = uihb_pkg::ST_ARP;
        end else begin
            w_req.status = uihb_pkg::ST_SENT;
        end
    end

    assign busy = !w_ready;

    uihb_cksum u_cksum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_req   (w_req),
        .o_ready (w_ready),
        .o_valid (w_valid3),
        .o_hdr   (w_hdr3),
        .i_take  (w_take)
    );

    uihb_ser u_ser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_valid3),
        .i_hdr         (w_hdr3),
        .o_take        (w_take),
        .o_strobe      (o_strobe),
        .o_header_word (o_header_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word),
        .o_out_link    (o_out_link),
        .o_status      (o_status)
    );

endmodule

// ----- test/udp_ipv4_ethernet_header_builder_unit_tb.sv -----
// Self-checking testbench for the UDP/IPv4/Ethernet header builder top level.
// Depends on uihb_pkg and udp_ipv4_ethernet_header_builder_unit, which needs uihb_cksum and uihb_ser.
// A built-in predictor of the 21-word header is compared with every result the block emits.
`timescale 1ns / 100ps

module udp_ipv4_ethernet_header_builder_unit_tb;

    // The slowest correct run is about a hundred and twenty requests of 21 result words
    // each, plus sender gaps and the pauses before register writes. This limit is far above.
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned SETTLE_TICKS = 10;
    localparam int unsigned REPORT_MAX   = 10;

    // One transmit request as the sender presents it.
    typedef struct {
        logic [31:0] local_ip;
        logic [31:0] remote_ip;
        logic [7:0]  proto;
        logic [15:0] local_port;
        logic [15:0] remote_port;
        logic [15:0] payload_len;
        logic [47:0] src_mac;
        logic        src_mac_ok;
        logic [47:0] dst_mac;
        logic        dst_mac_ok;
        logic [7:0]  link;
    } t_tx_request;

    // One header word as the block should emit it.
    typedef struct {
        logic [15:0] word;
        logic [4:0]  index;
        logic        last;
        logic [7:0]  link;
        logic [1:0]  status;
    } t_header_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [31:0] i_local_address = '0;
    logic [31:0] i_remote_address = '0;
    logic [7:0]  i_proto_number = '0;
    logic [15:0] i_local_port = '0;
    logic [15:0] i_remote_port = '0;
    logic [15:0] i_payload_length = '0;
    logic [47:0] i_source_mac = '0;
    logic        i_source_mac_found = 1'b0;
    logic [47:0] i_dest_mac = '0;
    logic        i_dest_mac_found = 1'b0;
    logic [7:0]  i_egress_link = '0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = uihb_pkg::CFG_CORE;
    logic [11:0] i_cfg_data = '0;
    logic        o_strobe;
    logic [15:0] o_header_word;
    logic [4:0]  o_word_index;
    logic        o_last_word;
    logic [7:0]  o_out_link;
    logic [1:0]  o_status;

    // Expected header words, oldest first, and the predictor's copy of the registers.
    t_header_word pending_words[$];
    logic [3:0]   core_id = '0;
    logic [11:0]  ident_tag = '0;

    int unsigned requests_sent = 0;
    int unsigned drops_sent = 0;
    int unsigned words_checked = 0;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;

    udp_ipv4_ethernet_header_builder_unit u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_local_address    (i_local_address),
        .i_remote_address   (i_remote_address),
        .i_proto_number     (i_proto_number),
        .i_local_port       (i_local_port),
        .i_remote_port      (i_remote_port),
        .i_payload_length   (i_payload_length),
        .i_source_mac       (i_source_mac),
        .i_source_mac_found (i_source_mac_found),
        .i_dest_mac         (i_dest_mac),
        .i_dest_mac_found   (i_dest_mac_found),
        .i_egress_link      (i_egress_link),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .o_strobe           (o_strobe),
        .o_header_word      (o_header_word),
        .o_word_index       (o_word_index),
        .o_last_word        (o_last_word),
        .o_out_link         (o_out_link),
        .o_status           (o_status)
    );

    always #10 i_clk = ~i_clk;

    // The watchdog ends a hung run. It counts every clock, reset included.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d header words still expected",
                     cycle_count, pending_words.size());
            $display("** udp_ipv4_ethernet_header_builder_unit: FAILED **");
            $finish;
        end
    end

    // Works out the words one accepted request must produce and appends them to the
    // expected queue. A missing source MAC is checked first, so a request that lacks
    // both MACs is dropped with the no-source status, not with an ARP request.
    function automatic void build_header_words(input t_tx_request r);
        logic [15:0]  hdr[uihb_pkg::HDR_WORDS];
        logic [15:0]  plen;
        logic [31:0]  sum;
        t_header_word w;
        if (!r.src_mac_ok || !r.dst_mac_ok) begin
            w.word   = '0;
            w.index  = '0;
            w.last   = 1'b1;
            w.link   = '0;
            w.status = r.src_mac_ok ? uihb_pkg::ST_ARP : uihb_pkg::ST_NO_SMAC;
            pending_words.push_back(w);
            drops_sent++;
            return;
        end
        // Oversized payloads are clamped so both length fields stay within 16 bits.
        plen = (r.payload_len > uihb_pkg::MAX_PAYLOAD) ? uihb_pkg::MAX_PAYLOAD
                                                        : r.payload_len;
        hdr[0]  = r.dst_mac[47:32];
        hdr[1]  = r.dst_mac[31:16];
        hdr[2]  = r.dst_mac[15:0];
        hdr[3]  = r.src_mac[47:32];
        hdr[4]  = r.src_mac[31:16];
        hdr[5]  = r.src_mac[15:0];
        hdr[6]  = 16'h0800;
        hdr[7]  = 16'h4500;
        hdr[8]  = plen + 16'd28;
        hdr[9]  = {core_id, ident_tag};
        hdr[10] = 16'h0000;
        hdr[11] = {8'h00, r.proto};
        hdr[12] = 16'h0000;
        hdr[13] = r.local_ip[31:16];
        hdr[14] = r.local_ip[15:0];
        hdr[15] = r.remote_ip[31:16];
        hdr[16] = r.remote_ip[15:0];
        hdr[17] = r.local_port;
        hdr[18] = r.remote_port;
        hdr[19] = plen + 16'd8;
        hdr[20] = 16'h0000;
        // IPv4 header checksum: one's-complement sum of the ten IP words with the
        // checksum word as zero, carries folded back in, then inverted.
        sum = '0;
        for (int i = 7; i <= 16; i++) sum += hdr[i];
        while (sum[31:16] != 0) sum = {16'h0000, sum[15:0]} + {16'h0000, sum[31:16]};
        hdr[12] = ~sum[15:0];
        for (int i = 0; i < uihb_pkg::HDR_WORDS; i++) begin
            w.word   = hdr[i];
            w.index  = 5'(i);
            w.last   = (i == uihb_pkg::HDR_WORDS - 1);
            w.link   = r.link;
            w.status = uihb_pkg::ST_SENT;
            pending_words.push_back(w);
        end
    endfunction

    // Every strobed result is matched against the oldest expected word. The receiver
    // cannot hold results off, so the check runs on every clock after reset.
    always @(posedge i_clk) begin
        t_header_word exp_w;
        if (i_rst_n && o_strobe === 1'b1) begin
            if (pending_words.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_MAX)
                    $display("Unexpected header word %h index %0d status %0d at cycle %0d",
                             o_header_word, o_word_index, o_status, cycle_count);
            end else begin
                exp_w = pending_words.pop_front();
                words_checked++;
                if (o_header_word !== exp_w.word || o_word_index !== exp_w.index ||
                    o_last_word !== exp_w.last || o_out_link !== exp_w.link ||
                    o_status !== exp_w.status) begin
                    error_count++;
                    if (error_count <= REPORT_MAX)
                        $display({"Mismatch at cycle %0d: word %h/%h index %0d/%0d ",
                                  "last %b/%b link %0d/%0d status %0d/%0d (expected/actual)"},
                                 cycle_count, exp_w.word, o_header_word,
                                 exp_w.index, o_word_index, exp_w.last, o_last_word,
                                 exp_w.link, o_out_link, exp_w.status, o_status);
                end
            end
        end
    end

    // Presents one request and holds it until an edge with busy low takes it. Start is
    // left high afterwards, so back-to-back requests keep it asserted without a dip.
    task automatic send_request(input t_tx_request r);
        @(negedge i_clk);
        start              <= 1'b1;
        i_local_address    <= r.local_ip;
        i_remote_address   <= r.remote_ip;
        i_proto_number     <= r.proto;
        i_local_port       <= r.local_port;
        i_remote_port      <= r.remote_port;
        i_payload_length   <= r.payload_len;
        i_source_mac       <= r.src_mac;
        i_source_mac_found <= r.src_mac_ok;
        i_dest_mac         <= r.dst_mac;
        i_dest_mac_found   <= r.dst_mac_ok;
        i_egress_link      <= r.link;
        do @(posedge i_clk); while (busy !== 1'b0);
        build_header_words(r);
        requests_sent++;
    endtask

    // Takes start low, so no request is on the port.
    task automatic idle_cycle();
        @(negedge i_clk);
        start <= 1'b0;
    endtask

    // Stops sending and waits until every expected word has arrived, then lets the
    // pipeline settle. The watchdog bounds the wait.
    task automatic drain_results();
        idle_cycle();
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    // Writes one configuration register. Only called after drain_results, so the
    // block is idle and the new value applies to every later request.
    task automatic write_register(input logic idx, input logic [11:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        if (idx == uihb_pkg::CFG_CORE) core_id = data[3:0];
        else ident_tag = data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_identification(input logic [11:0] core_data, input logic [11:0] tag);
        drain_results();
        write_register(uihb_pkg::CFG_CORE, core_data);
        write_register(uihb_pkg::CFG_TAG, tag);
    endtask

    // A random request. Most have both MACs so the full header is built; lengths are
    // mostly frame-sized, with full-range and near-limit values mixed in.
    function automatic t_tx_request random_request();
        t_tx_request r;
        int unsigned pick;
        r.local_ip    = $urandom;
        r.remote_ip   = $urandom;
        r.proto       = 8'($urandom);
        r.local_port  = 16'($urandom);
        r.remote_port = 16'($urandom);
        r.src_mac     = {16'($urandom), 32'($urandom)};
        r.dst_mac     = {16'($urandom), 32'($urandom)};
        r.src_mac_ok  = ($urandom_range(99) >= 6);
        r.dst_mac_ok  = ($urandom_range(99) >= 8);
        r.link        = 8'($urandom);
        pick = $urandom_range(99);
        if (pick < 60)      r.payload_len = 16'($urandom_range(1500));
        else if (pick < 85) r.payload_len = 16'($urandom);
        else                r.payload_len = 16'($urandom_range(65535, 65495));
        return r;
    endfunction

    // A fully formed request with every field set to one fill pattern.
    function automatic t_tx_request uniform_request(input logic fill, input logic [15:0] plen);
        t_tx_request r;
        r.local_ip    = {32{fill}};
        r.remote_ip   = {32{fill}};
        r.proto       = {8{fill}};
        r.local_port  = {16{fill}};
        r.remote_port = {16{fill}};
        r.payload_len = plen;
        r.src_mac     = {48{fill}};
        r.src_mac_ok  = 1'b1;
        r.dst_mac     = {48{fill}};
        r.dst_mac_ok  = 1'b1;
        r.link        = {8{fill}};
        return r;
    endfunction

    // Right after reset the identification must be zero: no register has been written.
    task automatic test_reset_identification();
        send_request(uniform_request(1'b0, 16'd0));
        send_request(random_request());
    endtask

    // Field extremes, the payload clamp around its limit, and every drop reason.
    task automatic test_directed_cases();
        t_tx_request r;
        send_request(uniform_request(1'b1, 16'hFFFF));
        send_request(uniform_request(1'b0, uihb_pkg::MAX_PAYLOAD));
        send_request(uniform_request(1'b1, uihb_pkg::MAX_PAYLOAD + 16'd1));
        send_request(uniform_request(1'b0, uihb_pkg::MAX_PAYLOAD - 16'd1));
        send_request(uniform_request(1'b1, 16'd0));
        // Alternating bit patterns make the two MACs differ in every bit; each address half is distinct.
        r = uniform_request(1'b0, 16'd1472);
        r.local_ip  = 32'hC0A8_0001;
        r.remote_ip = 32'h0A00_00FE;
        r.src_mac   = 48'hAA55_AA55_AA55;
        r.dst_mac   = 48'h55AA_55AA_55AA;
        r.proto     = 8'd17;
        r.link      = 8'h80;
        send_request(r);
        // Addresses chosen so the checksum sum carries more than once.
        r.local_ip  = 32'hFFFF_FFFF;
        r.remote_ip = 32'hFFFF_FFFE;
        r.proto     = 8'hFF;
        send_request(r);
        // Missing source MAC, alone and together with a missing destination.
        r.src_mac_ok = 1'b0;
        send_request(r);
        r.dst_mac_ok = 1'b0;
        send_request(r);
        // Missing destination MAC only: the block asks for ARP.
        r.src_mac_ok = 1'b1;
        send_request(r);
        r = uniform_request(1'b1, 16'hFFFF);
        r.dst_mac_ok = 1'b0;
        send_request(r);
        send_request(uniform_request(1'b1, 16'd100));
    endtask

    // Identification settings at both extremes and in between, a few requests each.
    // The core register is also written with its unused upper data bits set.
    task automatic test_identification_settings();
        set_identification(12'hFFF, 12'hFFF);
        repeat (3) send_request(random_request());
        set_identification(12'h000, 12'h000);
        repeat (2) send_request(random_request());
        set_identification(12'h008, 12'h800);
        repeat (2) send_request(random_request());
        set_identification(12'h007, 12'h7FF);
        repeat (2) send_request(random_request());
    endtask

    // Random requests with the sender idle in idle_pct cycles of a hundred. Now and then
    // the sender stops until every expected word has come, so gaps land on every phase of
    // a header; between pauses requests queue up behind the one being sent.
    task automatic run_random_phase(input int unsigned count, input int unsigned idle_pct);
        for (int unsigned n = 0; n < count; n++) begin
            while ($urandom_range(99) < idle_pct) idle_cycle();
            send_request(random_request());
            if ($urandom_range(19) == 0) drain_results();
        end
    endtask

    // Three idling phases. The result side cannot stall, so only the sender idles.
    // A new random identification is written before each phase.
    task automatic test_random_traffic();
        set_identification(12'($urandom), 12'($urandom));
        run_random_phase(32, 0);
        set_identification(12'($urandom), 12'($urandom));
        run_random_phase(32, 53);
        set_identification(12'($urandom), 12'($urandom));
        run_random_phase(33, 11);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_identification();
        test_directed_cases();
        test_identification_settings();
        test_random_traffic();

        // Wait out the last header; any word still expected after that is an error.
        drain_results();
        if (pending_words.size() != 0) error_count++;

        $display("Sent %0d requests (%0d dropped for a missing MAC) and checked %0d words.",
                 requests_sent, drops_sent, words_checked);
        $display("Covered field extremes, the payload clamp, both drop reasons, and several",
                 " identification settings under three sender idling levels.");
        if (error_count == 0) begin
            $display("** udp_ipv4_ethernet_header_builder_unit: PASSED **");
        end else begin
            $display("%0d errors", error_count);
            $display("** udp_ipv4_ethernet_header_builder_unit: FAILED **");
        end
        $finish;
    end

endmodule
